// ===== rtl/core/lcs_pkg.sv =====
package lcs_pkg;

  // Frame geometry, fixed by the sample ports.
  localparam int SENSOR_COUNT  = 8;
  localparam int SAMPLE_BITS   = 10;
  localparam int POSITION_STEP = 1000;

  // Derived datapath widths.
  localparam int TOTAL_W    = SAMPLE_BITS + $clog2(SENSOR_COUNT);
  localparam int WSUM_MAX   = ((1 << SAMPLE_BITS) - 1) * SENSOR_COUNT * (SENSOR_COUNT - 1) / 2;
  localparam int WSUM_W     = $clog2(WSUM_MAX + 1);
  localparam int DIVIDEND_W = $clog2(WSUM_MAX * POSITION_STEP + 1);
  localparam int QUOT_W     = $clog2((SENSOR_COUNT - 1) * POSITION_STEP + 1);

  // Divider: STEP_BITS quotient bits are produced in each cycle.
  localparam int STEP_BITS  = 4;
  localparam int ITERS      = (QUOT_W + STEP_BITS - 1) / STEP_BITS;
  localparam int QUOT_PAD   = ITERS * STEP_BITS;
  localparam int REM_W      = (DIVIDEND_W > TOTAL_W + QUOT_PAD) ? DIVIDEND_W
                                                                : TOTAL_W + QUOT_PAD;

  // Field widths of the result and configuration.
  localparam int POS_W       = 13;
  localparam int SPEED_W     = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 13;

  localparam logic [QUOT_W-1:0] POSITION_NONE = QUOT_W'(3500);

  localparam logic signed [1:0] DIR_FWD = 2'sb01;
  localparam logic signed [1:0] DIR_REV = 2'sb11;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_NOISE    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LEFT     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_RIGHT    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_STRAIGHT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_OUTER    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_INNER    = 3'd5;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] noise_threshold;
    logic [POS_W-1:0]       left_limit;
    logic [POS_W-1:0]       right_limit;
    logic [SPEED_W-1:0]     straight_speed;
    logic [SPEED_W-1:0]     outer_speed;
    logic [SPEED_W-1:0]     inner_speed;
  } cfg_t;

  // One classified frame waiting for the divider.
  typedef struct packed {
    logic                  found;
    logic [TOTAL_W-1:0]    total;
    logic [DIVIDEND_W-1:0] dividend;
  } job_t;

  typedef struct packed {
    logic busy;
    logic done;
  } back_status_t;

endpackage

// ===== rtl/core/line_centroid_steering.sv =====
// Line position and differential steering from one frame of eight sensors.
//
// Frame channel: sample_0 (leftmost) to sample_7 are taken as one request at a
// rising edge with frame_valid high and frame_stall low. Result channel: one
// request per frame, handed over when result_valid is high and result_stall is
// low. Configuration: cfg_index selects a register, cfg_data carries the value;
// cfg_ready is always high, so each cfg_valid cycle writes one register.
// Unknown indexes are dropped. Write the registers only while no frame is open.
//
// A new frame can be taken every cycle into the front end while frame_stall is
// low, but the sustained rate is set by the centroid divider, which starts a
// new frame only after finishing the last and retires four quotient bits per
// cycle over a 16 bit quotient. A short queue sits between the classifying
// front end and the divider, and the result register sits after it.
//
// Reset clears every pipeline stage and loads the register defaults (noise 600,
// limits 3000 and 4000, speeds 50, 35 and 20). When the receiver stalls, the
// result holds, the divider parks its finished quotient, the queue fills and
// then frame_stall rises.
module line_centroid_steering import lcs_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    frame_valid,
  output logic                    frame_stall,
  input  logic [SAMPLE_BITS-1:0]  sample_0,
  input  logic [SAMPLE_BITS-1:0]  sample_1,
  input  logic [SAMPLE_BITS-1:0]  sample_2,
  input  logic [SAMPLE_BITS-1:0]  sample_3,
  input  logic [SAMPLE_BITS-1:0]  sample_4,
  input  logic [SAMPLE_BITS-1:0]  sample_5,
  input  logic [SAMPLE_BITS-1:0]  sample_6,
  input  logic [SAMPLE_BITS-1:0]  sample_7,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic [POS_W-1:0]        line_position,
  output logic                    line_found,
  output logic signed [1:0]       left_direction,
  output logic [SPEED_W-1:0]      left_speed,
  output logic signed [1:0]       right_direction,
  output logic [SPEED_W-1:0]      right_speed,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  cfg_t                                    cfg;
  logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0] samples;
  logic                                    push;
  job_t                                    push_job;
  logic                                    queue_full;
  logic                                    queue_empty;
  logic                                    pop;
  job_t                                    head;
  back_status_t                            back_status;

  assign cfg_ready = 1'b1;

  always_comb begin
    samples[0] = sample_0;
    samples[1] = sample_1;
    samples[2] = sample_2;
    samples[3] = sample_3;
    samples[4] = sample_4;
    samples[5] = sample_5;
    samples[6] = sample_6;
    samples[7] = sample_7;
  end

  // Configuration registers. Each value is cut to its register width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.noise_threshold <= SAMPLE_BITS'(600);
      cfg.left_limit      <= POS_W'(3000);
      cfg.right_limit     <= POS_W'(4000);
      cfg.straight_speed  <= SPEED_W'(50);
      cfg.outer_speed     <= SPEED_W'(35);
      cfg.inner_speed     <= SPEED_W'(20);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_NOISE:    cfg.noise_threshold <= cfg_data[SAMPLE_BITS-1:0];
        REG_LEFT:     cfg.left_limit      <= cfg_data[POS_W-1:0];
        REG_RIGHT:    cfg.right_limit     <= cfg_data[POS_W-1:0];
        REG_STRAIGHT: cfg.straight_speed  <= cfg_data[SPEED_W-1:0];
        REG_OUTER:    cfg.outer_speed     <= cfg_data[SPEED_W-1:0];
        REG_INNER:    cfg.inner_speed     <= cfg_data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: masks noisy samples and forms the weighted and plain sums.
  lcs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .samples     (samples),
    .push        (push),
    .push_job    (push_job),
    .queue_full  (queue_full)
  );

  lcs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (queue_full),
    .pop      (pop),
    .head     (head),
    .empty    (queue_empty)
  );

  // Back end: divides out the centroid and makes the steering decision.
  lcs_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .head            (head),
    .queue_empty     (queue_empty),
    .pop             (pop),
    .status          (back_status),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .line_position   (line_position),
    .line_found      (line_found),
    .left_direction  (left_direction),
    .left_speed      (left_speed),
    .right_direction (right_direction),
    .right_speed     (right_speed)
  );

  // The two wheels are never reversed together.
  a_single_reverse: assert property (@(posedge clk) disable iff (rst)
    result_valid && (left_direction == DIR_REV) |-> (right_direction == DIR_FWD))
    else $error("both wheels reversed");

  // A frame with no active sample reports the center position.
  a_empty_center: assert property (@(posedge clk) disable iff (rst)
    result_valid && !line_found |-> (line_position == POS_W'(POSITION_NONE)))
    else $error("empty frame did not report the center position");

  // The divider never iterates while it still holds an unsent quotient.
  a_back_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(back_status.busy && back_status.done))
    else $error("divider busy while holding a finished quotient");

endmodule

// ===== rtl/core/lcs_front.sv =====
module lcs_front import lcs_pkg::*; (
  input  logic                                    clk,
  input  logic                                    rst,
  input  cfg_t                                    cfg,
  input  logic                                    frame_valid,
  output logic                                    frame_stall,
  input  logic [SENSOR_COUNT-1:0][SAMPLE_BITS-1:0] samples,
  output logic                                    push,
  output job_t                                    push_job,
  input  logic                                    queue_full
);

  logic               s1_valid;
  logic               s1_found;
  logic [TOTAL_W-1:0] s1_total;
  logic [WSUM_W-1:0]  s1_wsum;
  logic               s2_valid;
  job_t               s2_job;

  logic               s1_open;
  logic               s2_open;
  logic               found_acc;
  logic [TOTAL_W-1:0] total_acc;
  logic [WSUM_W-1:0]  wsum_acc;

  always_comb begin
    s2_open     = !s2_valid || !queue_full;
    s1_open     = !s1_valid || s2_open;
    frame_stall = !s1_open;
    push        = s2_valid && !queue_full;
    push_job    = s2_job;
  end

  // Only samples strictly above the noise floor take part in the centroid.
  always_comb begin
    found_acc = 1'b0;
    total_acc = '0;
    wsum_acc  = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if (samples[i] > cfg.noise_threshold) begin
        found_acc = 1'b1;
        total_acc = total_acc + TOTAL_W'(samples[i]);
        wsum_acc  = wsum_acc + WSUM_W'(samples[i]) * WSUM_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_open) begin
        s1_valid <= frame_valid;
      end
      if (s2_open) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_valid && s1_open) begin
      s1_found <= found_acc;
      s1_total <= total_acc;
      s1_wsum  <= wsum_acc;
    end
    if (s1_valid && s2_open) begin
      s2_job.found    <= s1_found;
      s2_job.total    <= s1_total;
      s2_job.dividend <= DIVIDEND_W'(s1_wsum) * DIVIDEND_W'(POSITION_STEP);
    end
  end

endmodule

// ===== rtl/core/lcs_queue.sv =====
module lcs_queue import lcs_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t head,
  output logic empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== rtl/core/lcs_back.sv =====
module lcs_back import lcs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  job_t                head,
  input  logic                queue_empty,
  output logic                pop,
  output back_status_t        status,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [POS_W-1:0]    line_position,
  output logic                line_found,
  output logic signed [1:0]   left_direction,
  output logic [SPEED_W-1:0]  left_speed,
  output logic signed [1:0]   right_direction,
  output logic [SPEED_W-1:0]  right_speed
);

  localparam int CNT_W = $clog2(ITERS + 1);
  localparam int CMP_W = (QUOT_W > POS_W) ? QUOT_W : POS_W;

  logic                busy;
  logic                done;
  logic [CNT_W-1:0]    cnt;
  logic [REM_W-1:0]    rem;
  logic [REM_W-1:0]    dsh;
  logic [QUOT_PAD-1:0] quot;
  logic                found;

  logic                out_free;
  logic                out_load;
  logic                step_en;
  logic                finish;
  logic [CNT_W-1:0]    cnt_next;
  logic [REM_W-1:0]    rem_next;
  logic [REM_W-1:0]    dsh_next;
  logic [QUOT_PAD-1:0] quot_next;
  logic [CMP_W-1:0]    pos;

  assign status = '{busy: busy, done: done};

  always_comb begin
    out_free = !result_valid || !result_stall;
    out_load = done && out_free;
    pop      = !queue_empty && !busy && (!done || out_load);
    step_en  = pop || busy;
    cnt_next = (pop ? '0 : cnt) + 1'b1;
    finish   = step_en && (cnt_next == CNT_W'(ITERS));
  end

  // Restoring division, several quotient bits per cycle. The first group is
  // taken straight from the queue head so a new frame starts without a bubble.
  always_comb begin
    rem_next  = pop ? REM_W'(head.dividend) : rem;
    dsh_next  = pop ? (REM_W'(head.total) << (QUOT_PAD - 1)) : dsh;
    quot_next = pop ? '0 : quot;
    for (int k = 0; k < STEP_BITS; k++) begin
      if (rem_next >= dsh_next) begin
        rem_next  = rem_next - dsh_next;
        quot_next = {quot_next[QUOT_PAD-2:0], 1'b1};
      end else begin
        quot_next = {quot_next[QUOT_PAD-2:0], 1'b0};
      end
      dsh_next = dsh_next >> 1;
    end
  end

  always_comb begin
    pos = found ? CMP_W'(quot[QUOT_W-1:0]) : CMP_W'(POSITION_NONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      done         <= 1'b0;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (step_en) begin
        busy <= !finish;
        cnt  <= cnt_next;
      end
      done <= finish || (done && !out_load);
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      rem  <= rem_next;
      dsh  <= dsh_next;
      quot <= quot_next;
    end
    if (pop) begin
      found <= head.found;
    end
    if (out_load) begin
      line_position <= pos[POS_W-1:0];
      line_found    <= found;
      // The left turn is tested first, so it wins when the limits cross.
      if (pos < CMP_W'(cfg.left_limit)) begin
        left_direction  <= DIR_REV;
        left_speed      <= cfg.inner_speed;
        right_direction <= DIR_FWD;
        right_speed     <= cfg.outer_speed;
      end else if (pos > CMP_W'(cfg.right_limit)) begin
        left_direction  <= DIR_FWD;
        left_speed      <= cfg.outer_speed;
        right_direction <= DIR_REV;
        right_speed     <= cfg.inner_speed;
      end else begin
        left_direction  <= DIR_FWD;
        left_speed      <= cfg.straight_speed;
        right_direction <= DIR_FWD;
        right_speed     <= cfg.straight_speed;
      end
    end
  end

endmodule
